// ----- rtl/bounded_deque_with_search_core_defines.svh -----
// Assertion macros for the bounded deque core.
// No dependencies; included by the top level only.
`ifndef BOUNDED_DEQUE_WITH_SEARCH_CORE_DEFINES_SVH
`define BOUNDED_DEQUE_WITH_SEARCH_CORE_DEFINES_SVH

// Condition that holds at every clock edge out of reset.
`define BDQ_ASSERT_ALWAYS(label, clk, rst_n, cond, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond)) \
        else $error(msg);

// Consequent that holds in the cycle after the antecedent.
`define BDQ_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ----- rtl/bdq_pkg.sv -----
// Shared types and constants for the bounded deque core.
// No dependencies; used by the cell and the top level.
package bdq_pkg;

    localparam int DEPTH_DEF      = 64;
    localparam int DATA_WIDTH_DEF = 32;
    localparam int CMD_W          = 3;
    localparam int VALUE_W        = 32;
    localparam int POS_W          = 7;
    localparam int STATUS_W       = 3;
    localparam int OUT_DATA_W     = 32;
    localparam int CNT_OUT_W      = 7;

    typedef enum logic [CMD_W-1:0] {
        CMD_PUSH_FRONT = 3'd0,
        CMD_PUSH_BACK  = 3'd1,
        CMD_POP_FRONT  = 3'd2,
        CMD_POP_BACK   = 3'd3,
        CMD_REMOVE     = 3'd4,
        CMD_CONTAINS   = 3'd5,
        CMD_READ_POS   = 3'd6
    } t_cmd_code;

    typedef enum logic [STATUS_W-1:0] {
        ST_OK        = 3'd0,
        ST_EMPTY     = 3'd1,
        ST_FULL      = 3'd2,
        ST_NOT_FOUND = 3'd3,
        ST_BAD_POS   = 3'd4
    } t_status;

    typedef struct packed {
        logic [CMD_W-1:0]   cmd;
        logic [VALUE_W-1:0] value;
        logic [POS_W-1:0]   position;
    } t_cmd;

    typedef struct packed {
        logic [STATUS_W-1:0]   status;
        logic [OUT_DATA_W-1:0] data;
        logic                  found;
        logic [CNT_OUT_W-1:0]  entry_count;
        logic                  is_empty;
    } t_res;

    typedef enum logic [1:0] {
        CELL_HOLD       = 2'd0,
        CELL_TAKE_LEFT  = 2'd1,
        CELL_TAKE_RIGHT = 2'd2,
        CELL_LOAD_KEY   = 2'd3
    } t_cell_op;

    typedef struct packed {
        logic     capture;
        logic     use_match;
        t_cell_op op;
    } t_cell_ctl;

endpackage

// ----- rtl/bdq_stream_if.sv -----
// Valid/ready channel carrying one payload per transaction.
// Payload type is supplied by the user, normally from bdq_pkg.
interface bdq_stream_if #(
    parameter type T = logic
);
    logic valid;
    logic ready;
    T     payload;

    modport source (output valid, output payload, input ready);
    modport sink   (input valid, input payload, output ready);
endinterface

// ----- rtl/bounded_deque_with_search_core.sv -----
// Bounded deque with search: a chain of DEPTH cells, one entry per cell.
// Steps: S_IDLE accepts, S_MATCH does cell compare/select, S_EXEC shifts and registers
// the result once the result register is free; the next command enters after commit.
// The result register lets the next command enter while a result waits.
// Reset (synchronous, active low) clears the count, the sequencer and result valid;
// cell contents stay undefined until written.
module bounded_deque_with_search_core #(
    parameter int DEPTH      = bdq_pkg::DEPTH_DEF,
    parameter int DATA_WIDTH = bdq_pkg::DATA_WIDTH_DEF
) (
    input  logic         i_clk,
    input  logic         i_rst_n,
    bdq_stream_if.sink   i_cmd,
    bdq_stream_if.source o_res
);

`include "bounded_deque_with_search_core_defines.svh"

    localparam int CNT_W = $clog2(DEPTH + 1);
    localparam int CMP_W = (CNT_W > bdq_pkg::POS_W) ? CNT_W : bdq_pkg::POS_W;

    typedef enum logic [2:0] {
        S_IDLE  = 3'b001,
        S_MATCH = 3'b010,
        S_EXEC  = 3'b100
    } t_state;

    t_state                        r_state, n_state;
    logic [bdq_pkg::CMD_W-1:0]     r_cmd;
    logic [DATA_WIDTH-1:0]         r_key;
    logic [bdq_pkg::POS_W-1:0]     r_pos;
    logic [CNT_W-1:0]              r_count, n_count;
    logic                          r_any;
    logic                          r_out_valid;
    bdq_pkg::t_res                 r_out, n_res;

    logic                          w_accept;
    logic                          w_commit;
    logic                          w_search;
    bdq_pkg::t_cell_ctl            w_ctl;
    bdq_pkg::t_cell_op             w_op;
    logic [CNT_W-1:0]              w_idx;
    logic [CMP_W-1:0]              w_pos_ext;
    logic                          w_pos_bad;
    logic [DEPTH-1:0]              w_m, w_m_dec, w_first, w_gem, w_sel;
    logic [DATA_WIDTH-1:0]         w_data [DEPTH];
    logic [DATA_WIDTH-1:0]         w_pick [DEPTH];
    logic [DATA_WIDTH-1:0]         w_pick_or;
    logic                          w_full, w_empty;

    assign w_accept   = i_cmd.valid && i_cmd.ready;
    assign i_cmd.ready = (r_state == S_IDLE);
    assign w_commit   = (r_state == S_EXEC) && (!r_out_valid || o_res.ready);
    assign w_search   = (r_cmd == bdq_pkg::CMD_REMOVE) || (r_cmd == bdq_pkg::CMD_CONTAINS);
    assign w_full     = (r_count == CNT_W'(DEPTH));
    assign w_empty    = (r_count == '0);

    assign w_pos_ext  = CMP_W'(r_pos);
    assign w_pos_bad  = (r_pos == '0) || (w_pos_ext > CMP_W'(r_count));

    assign w_m_dec    = w_m - DEPTH'(1);
    assign w_first    = w_m & ~w_m_dec;
    assign w_gem      = w_m | ~w_m_dec;

    always_comb begin
        case (r_cmd)
            bdq_pkg::CMD_PUSH_BACK: w_idx = r_count;
            bdq_pkg::CMD_POP_BACK:  w_idx = r_count - CNT_W'(1);
            bdq_pkg::CMD_READ_POS:  w_idx = CNT_W'(w_pos_ext - CMP_W'(1));
            default:                w_idx = '0;
        endcase
    end

    always_comb begin
        w_pick_or = '0;
        for (int k = 0; k < DEPTH; k++) begin
            w_pick_or = w_pick_or | w_pick[k];
        end
    end

    always_comb begin
        n_res             = '0;
        n_res.status      = bdq_pkg::ST_OK;
        n_count           = r_count;
        w_op              = bdq_pkg::CELL_HOLD;
        case (r_cmd)
            bdq_pkg::CMD_PUSH_FRONT, bdq_pkg::CMD_PUSH_BACK: begin
                if (w_full) begin
                    n_res.status = bdq_pkg::ST_FULL;
                end else begin
                    w_op    = (r_cmd == bdq_pkg::CMD_PUSH_FRONT) ?
                              bdq_pkg::CELL_TAKE_LEFT : bdq_pkg::CELL_LOAD_KEY;
                    n_count = r_count + CNT_W'(1);
                end
            end
            bdq_pkg::CMD_POP_FRONT, bdq_pkg::CMD_POP_BACK: begin
                if (w_empty) begin
                    n_res.status = bdq_pkg::ST_EMPTY;
                end else begin
                    n_res.data = bdq_pkg::OUT_DATA_W'(w_pick_or);
                    if (r_cmd == bdq_pkg::CMD_POP_FRONT) begin
                        w_op = bdq_pkg::CELL_TAKE_RIGHT;
                    end
                    n_count = r_count - CNT_W'(1);
                end
            end
            bdq_pkg::CMD_REMOVE: begin
                n_res.found = r_any;
                if (w_empty) begin
                    n_res.status = bdq_pkg::ST_EMPTY;
                end else if (!r_any) begin
                    n_res.status = bdq_pkg::ST_NOT_FOUND;
                end else begin
                    w_op    = bdq_pkg::CELL_TAKE_RIGHT;
                    n_count = r_count - CNT_W'(1);
                end
            end
            bdq_pkg::CMD_CONTAINS: begin
                n_res.found = r_any;
            end
            bdq_pkg::CMD_READ_POS: begin
                if (w_pos_bad) begin
                    n_res.status = bdq_pkg::ST_BAD_POS;
                end else begin
                    n_res.data = bdq_pkg::OUT_DATA_W'(w_pick_or);
                end
            end
            default: begin
            end
        endcase
        n_res.entry_count = bdq_pkg::CNT_OUT_W'(n_count);
        n_res.is_empty    = (n_count == '0);
    end

    always_comb begin
        w_ctl.capture   = (r_state == S_MATCH);
        w_ctl.use_match = w_search;
        w_ctl.op        = w_commit ? w_op : bdq_pkg::CELL_HOLD;
    end

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE:  if (w_accept) n_state = S_MATCH;
            S_MATCH: n_state = S_EXEC;
            S_EXEC:  if (w_commit) n_state = S_IDLE;
            default: n_state = S_IDLE;
        endcase
    end

    for (genvar g = 0; g < DEPTH; g++) begin : g_cell
        bdq_cell #(
            .DATA_WIDTH (DATA_WIDTH),
            .CNT_W      (CNT_W),
            .INDEX      (g)
        ) u_cell (
            .i_clk      (i_clk),
            .i_ctl      (w_ctl),
            .i_key      (r_key),
            .i_idx      (w_idx),
            .i_count    (r_count),
            .i_left     ((g == 0) ? r_key : w_data[(g == 0) ? 0 : g - 1]),
            .i_right    (w_data[(g == DEPTH - 1) ? g : g + 1]),
            .i_first    (w_first[g]),
            .i_ge_match (w_gem[g]),
            .o_data     (w_data[g]),
            .o_match    (w_m[g]),
            .o_sel      (w_sel[g]),
            .o_pick     (w_pick[g])
        );
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_count     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (w_commit) begin
                r_count     <= n_count;
                r_out_valid <= 1'b1;
            end else if (o_res.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_cmd <= i_cmd.payload.cmd;
            r_key <= DATA_WIDTH'(i_cmd.payload.value);
            r_pos <= i_cmd.payload.position;
        end
        if (r_state == S_MATCH) begin
            r_any <= |w_m;
        end
        if (w_commit) begin
            r_out <= n_res;
        end
    end

    assign o_res.valid   = r_out_valid;
    assign o_res.payload = r_out;

    `BDQ_ASSERT_ALWAYS(a_count_bound, i_clk, i_rst_n, r_count <= CNT_W'(DEPTH),
        "entry count above depth")
    `BDQ_ASSERT_NEXT(a_count_hold, i_clk, i_rst_n, r_state != S_EXEC, $stable(r_count),
        "entry count changed outside commit")
    `BDQ_ASSERT_ALWAYS(a_sel_onehot, i_clk, i_rst_n, (r_state != S_EXEC) || $onehot0(w_sel),
        "more than one cell selected")

endmodule

// ----- rtl/bdq_cell.sv -----
// One storage cell of the deque chain: entry, compare and neighbor shift.
// Depends on bdq_pkg for the cell control struct.
module bdq_cell #(
    parameter int DATA_WIDTH = bdq_pkg::DATA_WIDTH_DEF,
    parameter int CNT_W      = 7,
    parameter int INDEX      = 0
) (
    input  logic                  i_clk,
    input  bdq_pkg::t_cell_ctl    i_ctl,
    input  logic [DATA_WIDTH-1:0] i_key,
    input  logic [CNT_W-1:0]      i_idx,
    input  logic [CNT_W-1:0]      i_count,
    input  logic [DATA_WIDTH-1:0] i_left,
    input  logic [DATA_WIDTH-1:0] i_right,
    input  logic                  i_first,
    input  logic                  i_ge_match,
    output logic [DATA_WIDTH-1:0] o_data,
    output logic                  o_match,
    output logic                  o_sel,
    output logic [DATA_WIDTH-1:0] o_pick
);

    localparam logic [CNT_W-1:0] MY_IDX = CNT_W'(INDEX);

    logic [DATA_WIDTH-1:0] r_data;
    logic                  r_sel;
    logic                  r_ge;

    always_ff @(posedge i_clk) begin
        if (i_ctl.capture) begin
            r_sel <= i_ctl.use_match ? i_first    : (i_idx == MY_IDX);
            r_ge  <= i_ctl.use_match ? i_ge_match : (MY_IDX >= i_idx);
        end
        case (i_ctl.op)
            bdq_pkg::CELL_TAKE_LEFT: begin
                r_data <= i_left;
            end
            bdq_pkg::CELL_TAKE_RIGHT: begin
                if (r_ge) begin
                    r_data <= i_right;
                end
            end
            bdq_pkg::CELL_LOAD_KEY: begin
                if (r_sel) begin
                    r_data <= i_key;
                end
            end
            default: begin
            end
        endcase
    end

    assign o_data  = r_data;
    assign o_match = (r_data == i_key) && (MY_IDX < i_count);
    assign o_sel   = r_sel;
    assign o_pick  = r_sel ? r_data : '0;

endmodule
